// File: rtl/hbs_pkg.sv
// Heightmap bilinear sampler: shared constants, types and the lerp function.
// Used by every module of the sampler; depends on nothing.
package hbs_pkg;

  localparam int GRID_SIDE   = 256;
  localparam int FRAC_BITS   = 8;
  localparam int HEIGHT_BITS = 16;
  localparam int POS_BITS    = 16;
  localparam int EXT_BITS    = 8;
  localparam int IDX_BITS    = $clog2(GRID_SIDE);
  localparam int ADDR_BITS   = 2 * IDX_BITS;
  localparam int MEM_DEPTH   = GRID_SIDE * GRID_SIDE;
  localparam int CFG_IDX_BITS = 1;

  localparam int IN_DATA_BITS  = 2 * POS_BITS + 2 * IDX_BITS + HEIGHT_BITS;
  localparam int OUT_DATA_BITS = HEIGHT_BITS;

  // result buffer; sized to cover the items accepted back to back before their push
  localparam int OUT_DEPTH = 8;
  localparam int PTR_BITS  = $clog2(OUT_DEPTH);
  localparam int OCC_BITS  = $clog2(OUT_DEPTH + 1);

  localparam logic [EXT_BITS-1:0] EXTENT_RESET = EXT_BITS'(40);
  localparam logic [POS_BITS-1:0] POS_LO       = POS_BITS'(2 * (2 ** FRAC_BITS));

  typedef logic signed [HEIGHT_BITS-1:0] height_t;

  localparam height_t OOR_HEIGHT = HEIGHT_BITS'(-(2 ** FRAC_BITS));

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_EXTENT_X = 1'b0,
    REG_EXTENT_Z = 1'b1
  } reg_idx_t;

  // stage strobes from the sequencer to the interpolator
  typedef struct packed {
    logic                 cap_up;
    logic                 calc_a;
    logic                 cap_left;
    logic                 calc_b;
    logic                 push;
    logic                 push_inr;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fz;
  } ctl_t;

  // a + floor((b - a) * f / 2^FRAC_BITS); result always lies between a and b
  function automatic height_t lerp(height_t a, height_t b, logic [FRAC_BITS-1:0] f);
    logic signed [HEIGHT_BITS:0]             d;
    logic signed [HEIGHT_BITS+FRAC_BITS+1:0] p;
    logic signed [HEIGHT_BITS:0]             s;
    logic signed [HEIGHT_BITS:0]             sum;
    d   = $signed({b[HEIGHT_BITS-1], b}) - $signed({a[HEIGHT_BITS-1], a});
    p   = d * $signed({1'b0, f});
    s   = $signed(p[HEIGHT_BITS+FRAC_BITS:FRAC_BITS]);
    sum = $signed({a[HEIGHT_BITS-1], a}) + s;
    return height_t'(sum[HEIGHT_BITS-1:0]);
  endfunction

endpackage

// File: rtl/hbs_height_mem.sv
// Heightmap store: one write port, one read port, registered read data.
// Depends on hbs_pkg for depth and widths.
module hbs_height_mem (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [hbs_pkg::ADDR_BITS-1:0]  wr_addr,
  input  hbs_pkg::height_t               wr_data,
  input  logic                           rd_en,
  input  logic [hbs_pkg::ADDR_BITS-1:0]  rd_addr,
  output hbs_pkg::height_t               rd_data_r
);

  hbs_pkg::height_t mem [0:hbs_pkg::MEM_DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/hbs_ctrl.sv
// Sequencer: item acceptance, extent registers, range check, corner read
// addresses and the stage strobes. Depends on hbs_pkg.
module hbs_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hbs_pkg::IN_DATA_BITS-1:0]  in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_wen,
  input  logic [hbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hbs_pkg::EXT_BITS-1:0]      cfg_wdata,
  input  logic                              out_pop,
  output logic                              wr_en,
  output logic [hbs_pkg::ADDR_BITS-1:0]     wr_addr,
  output hbs_pkg::height_t                  wr_data,
  output logic                              rd_en,
  output logic [hbs_pkg::ADDR_BITS-1:0]     rd_addr,
  output hbs_pkg::ctl_t                     ctl
);

  localparam int PB = hbs_pkg::POS_BITS;
  localparam int FB = hbs_pkg::FRAC_BITS;
  localparam int IB = hbs_pkg::IDX_BITS;
  localparam int NSTAGE = 5;

  logic [hbs_pkg::EXT_BITS-1:0] ext_x_r, ext_z_r;
  logic [NSTAGE-1:0]            vld_r, inr_r;
  logic [hbs_pkg::OCC_BITS-1:0] occ_r, occ_nxt;
  logic [IB-1:0]                x0_r, x1_r, z0_r, z1_r;
  logic [FB-1:0]                fx_r, fz_r;

  logic [PB-1:0] pos_x, pos_z, hi_x, hi_z;
  logic [IB-1:0] ld_row, ld_col, x0, x1, z0, z1;
  logic [FB-1:0] fx, fz;
  logic          accept, query, in_rng, busy;

  assign pos_x  = in_tdata[PB-1:0];
  assign pos_z  = in_tdata[2*PB-1:PB];
  assign ld_row = in_tdata[2*PB+IB-1:2*PB];
  assign ld_col = in_tdata[2*PB+2*IB-1:2*PB+IB];

  assign x0 = pos_x[PB-1:FB];
  assign z0 = pos_z[PB-1:FB];
  assign fx = pos_x[FB-1:0];
  assign fz = pos_z[FB-1:0];
  assign x1 = x0 + IB'(fx != '0);
  assign z1 = z0 + IB'(fz != '0);

  assign hi_x = {ext_x_r - hbs_pkg::EXT_BITS'(1), {FB{1'b0}}};
  assign hi_z = {ext_z_r - hbs_pkg::EXT_BITS'(1), {FB{1'b0}}};

  // zero extent wraps the upper bound, so it is excluded explicitly: always out of range
  assign in_rng = (pos_x >= hbs_pkg::POS_LO) && (pos_z >= hbs_pkg::POS_LO) &&
                  (ext_x_r != '0) && (ext_z_r != '0) &&
                  (pos_x <= hi_x) && (pos_z <= hi_z);

  // an in-range query holds the read port for its four corner reads
  assign busy      = inr_r[0] | inr_r[1] | inr_r[2];
  assign in_tready = !busy && (occ_r < hbs_pkg::OCC_BITS'(hbs_pkg::OUT_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign query     = accept && (hbs_pkg::func_t'(in_tuser) == hbs_pkg::FUNC_QUERY);

  assign wr_en   = accept && (hbs_pkg::func_t'(in_tuser) == hbs_pkg::FUNC_LOAD);
  assign wr_addr = {ld_row, ld_col};
  assign wr_data = hbs_pkg::height_t'(in_tdata[hbs_pkg::IN_DATA_BITS-1:2*PB+2*IB]);

  // corner reads in order up, right, left, down
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = {x0, z0};
    if (query && in_rng) begin
      rd_addr = {x0, z0};
    end else if (inr_r[0]) begin
      rd_addr = {x1_r, z0_r};
    end else if (inr_r[1]) begin
      rd_addr = {x0_r, z1_r};
    end else if (inr_r[2]) begin
      rd_addr = {x1_r, z1_r};
    end else begin
      rd_en = 1'b0;
    end
  end

  assign occ_nxt = occ_r + hbs_pkg::OCC_BITS'(query) - hbs_pkg::OCC_BITS'(out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_x_r <= hbs_pkg::EXTENT_RESET;
      ext_z_r <= hbs_pkg::EXTENT_RESET;
      vld_r   <= '0;
      inr_r   <= '0;
      occ_r   <= '0;
    end else begin
      if (cfg_wen) begin
        case (hbs_pkg::reg_idx_t'(cfg_index))
          hbs_pkg::REG_EXTENT_X: ext_x_r <= cfg_wdata;
          hbs_pkg::REG_EXTENT_Z: ext_z_r <= cfg_wdata;
          default: ;
        endcase
      end
      vld_r <= {vld_r[NSTAGE-2:0], query};
      inr_r <= {inr_r[NSTAGE-2:0], query && in_rng};
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (query) begin
      x0_r <= x0;
      x1_r <= x1;
      z0_r <= z0;
      z1_r <= z1;
      fx_r <= fx;
      fz_r <= fz;
    end
  end

  assign ctl.cap_up   = inr_r[0];
  assign ctl.calc_a   = inr_r[1];
  assign ctl.cap_left = inr_r[2];
  assign ctl.calc_b   = inr_r[3];
  assign ctl.push     = vld_r[4];
  assign ctl.push_inr = inr_r[4];
  assign ctl.fx       = fx_r;
  assign ctl.fz       = fz_r;

endmodule

// File: rtl/hbs_interp.sv
// Interpolator: captures corner heights off the read port and does the x
// then z lerps. Depends on hbs_pkg.
module hbs_interp (
  input  logic             clk,
  input  hbs_pkg::ctl_t    ctl,
  input  hbs_pkg::height_t rd_data,
  output hbs_pkg::height_t res_height
);

  hbs_pkg::height_t               up_r, left_r, a_r, b_r;
  logic [hbs_pkg::FRAC_BITS-1:0]  fz_b_r;

  always_ff @(posedge clk) begin
    if (ctl.cap_up) begin
      up_r <= rd_data;
    end
    if (ctl.calc_a) begin
      a_r <= hbs_pkg::lerp(up_r, rd_data, ctl.fx);
    end
    if (ctl.cap_left) begin
      left_r <= rd_data;
    end
    // fz is held here: the next query may overwrite the sequencer copy
    if (ctl.calc_b) begin
      b_r    <= hbs_pkg::lerp(left_r, rd_data, ctl.fx);
      fz_b_r <= ctl.fz;
    end
  end

  assign res_height = ctl.push_inr ? hbs_pkg::lerp(a_r, b_r, fz_b_r) : hbs_pkg::OOR_HEIGHT;

endmodule

// File: rtl/hbs_out_fifo.sv
// Result buffer between the interpolator and the output channel.
// Depends on hbs_pkg; never overflows as the sequencer counts items in flight.
module hbs_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hbs_pkg::height_t push_height,
  input  logic             push_inr,
  output logic             out_tvalid,
  input  logic             out_tready,
  output hbs_pkg::height_t out_tdata,
  output logic             out_tuser
);

  hbs_pkg::height_t              data_r [0:hbs_pkg::OUT_DEPTH-1];
  logic [hbs_pkg::OUT_DEPTH-1:0] flag_r;
  logic [hbs_pkg::PTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [hbs_pkg::OCC_BITS-1:0]  cnt_r;
  logic                          pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = data_r[rd_ptr_r];
  assign out_tuser  = flag_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_height;
      flag_r[wr_ptr_r] <= push_inr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + hbs_pkg::PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + hbs_pkg::PTR_BITS'(1);
      end
      cnt_r <= cnt_r + hbs_pkg::OCC_BITS'(push) - hbs_pkg::OCC_BITS'(pop);
    end
  end

endmodule

// File: rtl/heightmap_bilinear_sampler_core.sv
// Heightmap bilinear sampler, top level.
// Depends on hbs_pkg, hbs_ctrl, hbs_height_mem, hbs_interp, hbs_out_fifo.
//
//   channel   direction  payload
//   in_*      in         tuser: func; tdata: pos_x, pos_z, load_row, load_col, load_height
//   out_*     out        tuser: in_range; tdata: height
//   cfg_*     in         cfg_index selects extent_x / extent_z, cfg_wdata 8 bits
//
// An in-range query holds the single memory read port for four corner reads,
// so no item enters until its last corner read has been issued; out-of-range
// queries and loads can enter every cycle while the result buffer has room.
// Query results are pushed into the result buffer and leave it in order.
// rst_n is synchronous; heightmap contents are not cleared.
// Up to eight queries are in flight or buffered; at eight in_tready drops.
module heightmap_bilinear_sampler_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] pos_x, [31:16] pos_z, [39:32] load_row, [47:40] load_col,
  // [63:48] load_height
  input  logic [hbs_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // [0] func
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] height
  output logic [hbs_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // [0] in_range
  output logic                              out_tuser,
  input  logic                              cfg_wen,
  input  logic [hbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hbs_pkg::EXT_BITS-1:0]      cfg_wdata
);

  logic                          wr_en, rd_en, out_pop;
  logic [hbs_pkg::ADDR_BITS-1:0] wr_addr, rd_addr;
  hbs_pkg::height_t              wr_data, rd_data, res_height, fifo_height;
  hbs_pkg::ctl_t                 ctl;

  assign out_pop   = out_tvalid && out_tready;
  assign out_tdata = fifo_height;

  hbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_pop   (out_pop),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .ctl       (ctl)
  );

  hbs_height_mem u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  hbs_interp u_interp (
    .clk        (clk),
    .ctl        (ctl),
    .rd_data    (rd_data),
    .res_height (res_height)
  );

  hbs_out_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (ctl.push),
    .push_height (res_height),
    .push_inr    (ctl.push_inr),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (fifo_height),
    .out_tuser   (out_tuser)
  );

endmodule
